@@ rtl/trcp_pkg.sv @@
`default_nettype none

package trcp_pkg;

   // Default sizing, handed down from the top level
   localparam int SLOT_COUNT_DEF = 32768;
   localparam int MAX_GROUP_DEF  = 16;

   // Field and register widths
   localparam int SLOT_W     = 15;
   localparam int CAP_W      = 16;
   localparam int BITRATE_W  = 30;
   localparam int GRP_W      = 5;
   localparam int CREDIT_W   = 36;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   // Command queue between front and back
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;

   // Bits charged for one packet: 188 bytes, 8 bits, per microsecond tick
   localparam int PKT_BYTES    = 188;
   localparam int USEC_PER_SEC = 1000000;
   localparam logic [CREDIT_W-1:0] PKT_COST = CREDIT_W'(PKT_BYTES * 8 * USEC_PER_SEC);

   // Register reset values
   localparam logic [BITRATE_W-1:0] BITRATE_RST  = BITRATE_W'(100000000);
   localparam logic [GRP_W-1:0]     GROUP_RST    = GRP_W'(7);
   localparam logic [CAP_W-1:0]     CAPACITY_RST = CAP_W'(30000);
   localparam logic [CAP_W-1:0]     PREFILL_RST  = CAP_W'(10000);
   localparam logic                 REFILL_RST   = 1'b0;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITRATE  = 3'd0,
      CSR_GROUP    = 3'd1,
      CSR_CAPACITY = 3'd2,
      CSR_PREFILL  = 3'd3,
      CSR_REFILL   = 3'd4
   } csr_index_type;

   // Request kinds and result kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;
   localparam logic RK_WRITE   = 1'b0;
   localparam logic RK_SEND    = 1'b1;

   // Effective configuration seen by front and back
   typedef struct packed {
      logic [BITRATE_W-1:0] bitrate;
      logic [GRP_W-1:0]     grp;
      logic [CAP_W-1:0]     cap;
      logic [CAP_W-1:0]     prefill;
      logic                 refill;
   } cfg_type;

   // Command handed from front to back
   typedef struct packed {
      logic kind;
      logic drained;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/trcp_if.sv @@
`default_nettype none

// Request channel: one write request or one microsecond tick
interface trcp_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic source_drained;

   modport source (output valid, kind, source_drained, input ready);
   modport sink   (input valid, kind, source_drained, output ready);
endinterface

// Response channel: write answers and send descriptors
interface trcp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      result_kind;
   logic                      accepted;
   logic [trcp_pkg::SLOT_W-1:0] slot;
   logic                      is_null;
   logic                      last;
   logic [trcp_pkg::SLOT_W-1:0] occupancy;

   modport source (output valid, result_kind, accepted, slot, is_null, last, occupancy,
                   input ready);
   modport sink   (input valid, result_kind, accepted, slot, is_null, last, occupancy,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/trcp_front.sv @@
`default_nettype none

module trcp_front (
   input  wire                 clock,
   input  wire                 reset,
   trcp_req_if.sink            req,
   input  trcp_pkg::cfg_type   cfg,
   input  wire                 cmd_full,
   output logic                cmd_push,
   output trcp_pkg::cmd_type   cmd_data
);

   localparam int CW = trcp_pkg::CREDIT_W;

   logic          stage_valid_ff, stage_valid_in;
   logic          stage_kind_ff, stage_kind_in;
   logic          stage_drained_ff, stage_drained_in;
   logic [CW-1:0] credit_ff, credit_in;
   logic [CW-1:0] cost_ff, cost_in;
   logic [CW-1:0] br_ext;
   logic [CW-1:0] sum_add;
   logic [CW-1:0] sum_charge;
   logic          has_credit;
   logic          is_write;

   // Cost of one full group, registered after the multiply
   assign cost_in = {{(CW-trcp_pkg::GRP_W){1'b0}}, cfg.grp} * trcp_pkg::PKT_COST;

   // Credit add and add-minus-charge in parallel
   assign br_ext     = {{(CW-trcp_pkg::BITRATE_W){1'b0}}, cfg.bitrate};
   assign sum_add    = credit_ff + br_ext;
   assign sum_charge = credit_ff + br_ext - cost_ff;
   assign has_credit = !sum_add[CW-1] && (sum_add != '0);
   assign is_write   = (stage_kind_ff == trcp_pkg::KIND_WRITE);

   assign req.ready = !stage_valid_ff;

   assign cmd_data.kind    = stage_kind_ff;
   assign cmd_data.drained = stage_drained_ff;

   // Classify the staged request: writes and paid ticks go to the back
   always_comb begin
      cmd_push         = 1'b0;
      stage_valid_in   = stage_valid_ff;
      stage_kind_in    = stage_kind_ff;
      stage_drained_in = stage_drained_ff;
      credit_in        = credit_ff;
      if (stage_valid_ff) begin
         if (is_write) begin
            if (!cmd_full) begin
               cmd_push       = 1'b1;
               stage_valid_in = 1'b0;
            end
         end else if (has_credit) begin
            if (!cmd_full) begin
               cmd_push       = 1'b1;
               stage_valid_in = 1'b0;
               credit_in      = sum_charge;
            end
         end else begin
            stage_valid_in = 1'b0;
            credit_in      = sum_add;
         end
      end else if (req.valid) begin
         stage_valid_in   = 1'b1;
         stage_kind_in    = req.kind;
         stage_drained_in = req.source_drained;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         credit_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         credit_ff      <= credit_in;
      end
      stage_kind_ff    <= stage_kind_in;
      stage_drained_ff <= stage_drained_in;
      cost_ff          <= cost_in;
   end

`ifndef SYNTHESIS
   // Credit is charged a whole group, which always exceeds one tick's bitrate
   a_credit_not_positive: assert property (@(posedge clock) disable iff (reset)
      credit_ff[CW-1] || (credit_ff == '0))
      else $error("credit positive between ticks");

   // A paid tick always lands below zero after the charge
   a_charge_lands_low: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && !is_write) |=> (credit_ff[CW-1] || (credit_ff == '0)))
      else $error("credit positive after group charge");
`endif

endmodule

`default_nettype wire

@@ rtl/trcp_cmd_fifo.sv @@
`default_nettype none

module trcp_cmd_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  trcp_pkg::cmd_type   din,
   input  wire                 pop,
   output trcp_pkg::cmd_type   dout,
   output logic                full,
   output logic                empty
);

   localparam int DEPTH = trcp_pkg::CMD_DEPTH;
   localparam int PW    = trcp_pkg::CMD_PTR_W;
   localparam int CNTW  = trcp_pkg::CMD_CNT_W;

   trcp_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // Pointer and count update; depth is a power of two so pointers wrap
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

`ifndef SYNTHESIS
   // Fill level stays within the queue depth and agrees with the pointers
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNTW'(DEPTH)) &&
      ((wr_ptr_ff - rd_ptr_ff) == count_ff[PW-1:0]))
      else $error("command queue count out of step");
`endif

endmodule

`default_nettype wire

@@ rtl/trcp_back.sv @@
`default_nettype none

module trcp_back (
   input  wire                 clock,
   input  wire                 reset,
   input  trcp_pkg::cfg_type   cfg,
   input  wire                 cmd_empty,
   input  trcp_pkg::cmd_type   cmd_data,
   output logic                cmd_pop,
   trcp_rsp_if.source          rsp
);

   localparam int SW = trcp_pkg::SLOT_W;
   localparam int CW = trcp_pkg::CAP_W;
   localparam int GW = trcp_pkg::GRP_W;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic [SW-1:0] fill_ff, fill_in;
   logic          ready_ff, ready_in;
   logic [GW-1:0] cnt_ff, cnt_in;
   logic          ring_ff, ring_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rk_ff, rk_in;
   logic          acc_ff, acc_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          null_ff, null_in;
   logic          last_ff, last_in;
   logic [SW-1:0] occ_ff, occ_in;

   logic          out_free;
   logic [CW-1:0] wr_next, rd_next, fill_inc;
   logic [SW-1:0] wr_adv, rd_adv, fill_dec;
   logic          ring_full;
   logic          grp_end;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Pointer advance with wrap at the capacity in effect
   assign wr_next   = {1'b0, write_slot_ff} + CW'(1);
   assign rd_next   = {1'b0, read_slot_ff} + CW'(1);
   assign wr_adv    = (wr_next >= cfg.cap) ? '0 : wr_next[SW-1:0];
   assign rd_adv    = (rd_next >= cfg.cap) ? '0 : rd_next[SW-1:0];
   assign fill_inc  = {1'b0, fill_ff} + CW'(1);
   assign fill_dec  = fill_ff - SW'(1);
   assign ring_full = (fill_inc >= cfg.cap);
   assign grp_end   = ((cnt_ff + GW'(1)) == cfg.grp);

   // Sequencer: one write answer, or one descriptor per cycle of a group while the output is free
   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      fill_in       = fill_ff;
      ready_in      = ready_ff;
      cnt_in        = cnt_ff;
      ring_in       = ring_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rk_in         = rk_ff;
      acc_in        = acc_ff;
      slot_in       = slot_ff;
      null_in       = null_ff;
      last_in       = last_ff;
      occ_in        = occ_ff;
      cmd_pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_data.kind == trcp_pkg::KIND_WRITE) begin
                  rsp_valid_in = 1'b1;
                  rk_in        = trcp_pkg::RK_WRITE;
                  null_in      = 1'b0;
                  last_in      = 1'b1;
                  if (ring_full) begin
                     acc_in  = 1'b0;
                     slot_in = '0;
                     occ_in  = fill_ff;
                  end else begin
                     acc_in        = 1'b1;
                     slot_in       = write_slot_ff;
                     occ_in        = fill_inc[SW-1:0];
                     write_slot_in = wr_adv;
                     fill_in       = fill_inc[SW-1:0];
                     if (fill_inc > cfg.prefill) begin
                        ready_in = 1'b1;
                     end
                  end
               end else begin
                  ring_in  = (ready_ff || cmd_data.drained) && (fill_ff != '0);
                  cnt_in   = '0;
                  state_in = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rk_in        = trcp_pkg::RK_SEND;
               acc_in       = 1'b1;
               if (ring_ff) begin
                  slot_in      = read_slot_ff;
                  null_in      = 1'b0;
                  occ_in       = fill_dec;
                  last_in      = grp_end || (fill_dec == '0);
                  fill_in      = fill_dec;
                  read_slot_in = rd_adv;
                  if ((fill_dec == '0) && cfg.refill) begin
                     ready_in = 1'b0;
                  end
               end else begin
                  slot_in = '0;
                  null_in = 1'b1;
                  occ_in  = fill_ff;
                  last_in = grp_end;
               end
               if (last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + GW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         ready_ff      <= ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cnt_ff  <= cnt_in;
      ring_ff <= ring_in;
      rk_ff   <= rk_in;
      acc_ff  <= acc_in;
      slot_ff <= slot_in;
      null_ff <= null_in;
      last_ff <= last_in;
      occ_ff  <= occ_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rk_ff;
   assign rsp.accepted    = acc_ff;
   assign rsp.slot        = slot_ff;
   assign rsp.is_null     = null_ff;
   assign rsp.last        = last_ff;
   assign rsp.occupancy   = occ_ff;

`ifndef SYNTHESIS
   // Fill level moves by at most one packet per cycle
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((fill_ff == $past(fill_ff)) ||
                         (fill_ff == $past(fill_ff) + SW'(1)) ||
                         (fill_ff == $past(fill_ff) - SW'(1))))
      else $error("fill level jumped");

   // A refused write only happens with the ring at capacity
   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rk_ff == trcp_pkg::RK_WRITE) && !acc_ff)
         |-> (({1'b0, occ_ff} + CW'(1)) >= cfg.cap))
      else $error("write refused below capacity");

   // Group counter stays inside the group while sending
   a_cnt_in_group: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (cnt_ff < cfg.grp))
      else $error("group counter overran");
`endif

endmodule

`default_nettype wire

@@ rtl/ts_ring_cbr_pacer.sv @@
// Constant-bitrate pacer for a ring of 188-byte transport packets held elsewhere.
// Request channel (req_chan): kind 0 asks for a slot for one incoming packet,
// kind 1 is a microsecond tick; source_drained on a tick sends what is buffered.
// Response channel (rsp_chan): a write answer (granted slot or refusal) for each
// write request; for a tick with positive credit, one group of send descriptors
// (cut short if the ring empties), from the ring or null packets, the last one flagged; a tick without credit
// gives nothing. occupancy is the ring fill after each response.
// Path: a request is staged in the front, queued, then handled at the back; a
// write answer is registered in the back's output register when its command is
// popped; a paid tick first moves the back to its send state, which then registers each descriptor.
// Throughput: the front stage holds one request and takes no new one until it
// has passed the staged request on; the back answers a write directly, and for
// a tick opens a group, then gives one descriptor per cycle while the output is free.
// A two-entry command queue lets the front keep taking requests while the back
// works; when the receiver stalls the output register holds, the back stops,
// the queue fills and req_chan.ready drops.
// Reset (synchronous, active high) empties the ring, clears ready and credit,
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module ts_ring_cbr_pacer #(
   parameter int SLOT_COUNT = trcp_pkg::SLOT_COUNT_DEF,
   parameter int MAX_GROUP  = trcp_pkg::MAX_GROUP_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   trcp_req_if.sink                              req_chan,
   trcp_rsp_if.source                            rsp_chan,
   input  wire                                   csr_wr_en,
   input  wire  [trcp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [trcp_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int BW = trcp_pkg::BITRATE_W;
   localparam int GW = trcp_pkg::GRP_W;
   localparam int CW = trcp_pkg::CAP_W;

   logic [BW-1:0] bitrate_ff, bitrate_in;
   logic [GW-1:0] group_ff, group_in;
   logic [CW-1:0] capacity_ff, capacity_in;
   logic [CW-1:0] prefill_ff, prefill_in;
   logic          refill_ff, refill_in;

   trcp_pkg::cfg_type cfg;
   trcp_pkg::cmd_type push_data, pop_data;
   logic              cmd_push, cmd_pop, cmd_full, cmd_empty;

   // Register writes
   always_comb begin
      bitrate_in  = bitrate_ff;
      group_in    = group_ff;
      capacity_in = capacity_ff;
      prefill_in  = prefill_ff;
      refill_in   = refill_ff;
      if (csr_wr_en) begin
         case (csr_index)
            trcp_pkg::CSR_BITRATE:  bitrate_in  = csr_wr_data[BW-1:0];
            trcp_pkg::CSR_GROUP:    group_in    = csr_wr_data[GW-1:0];
            trcp_pkg::CSR_CAPACITY: capacity_in = csr_wr_data[CW-1:0];
            trcp_pkg::CSR_PREFILL:  prefill_in  = csr_wr_data[CW-1:0];
            trcp_pkg::CSR_REFILL:   refill_in   = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitrate_ff  <= trcp_pkg::BITRATE_RST;
         group_ff    <= trcp_pkg::GROUP_RST;
         capacity_ff <= trcp_pkg::CAPACITY_RST;
         prefill_ff  <= trcp_pkg::PREFILL_RST;
         refill_ff   <= trcp_pkg::REFILL_RST;
      end else begin
         bitrate_ff  <= bitrate_in;
         group_ff    <= group_in;
         capacity_ff <= capacity_in;
         prefill_ff  <= prefill_in;
         refill_ff   <= refill_in;
      end
   end

   // Clamp group size (zero taken as one) and capacity to what the build supports
   always_comb begin
      cfg.bitrate = bitrate_ff;
      cfg.prefill = prefill_ff;
      cfg.refill  = refill_ff;
      cfg.cap     = (capacity_ff > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : capacity_ff;
      if (group_ff == '0) begin
         cfg.grp = GW'(1);
      end else if (group_ff > GW'(MAX_GROUP)) begin
         cfg.grp = GW'(MAX_GROUP);
      end else begin
         cfg.grp = group_ff;
      end
   end

   trcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .cfg      (cfg),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (push_data)
   );

   trcp_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (push_data),
      .pop   (cmd_pop),
      .dout  (pop_data),
      .full  (cmd_full),
      .empty (cmd_empty)
   );

   trcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (pop_data),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
